// ===== hw/rtl/fbx_pkg.sv =====
// Shared types, constants and helper functions for the bit-plane sprite framebuffer.
// Depends on nothing; every other file except fbx_ram imports it.
`default_nettype none

package fbx_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int DEPTH         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(DEPTH);

  localparam int PLANE_BITS = 7;
  localparam int PIX_W      = 8;
  localparam int PX_W       = 7;   // pos_x field
  localparam int PY_W       = 6;   // pos_y field
  localparam int RC_W       = 4;   // row_count field
  localparam int COL_W      = PX_W + 1;  // column plus sprite offset
  localparam int ROW_W      = PY_W + 1;  // row plus row offset
  localparam int CNT_W      = 3;   // number of enabled planes, 0..7
  localparam int BYTES_W    = 7;   // bytes taken, up to 15 * 7
  localparam int MAX_BYTES  = 15 * PLANE_BITS;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_ROW   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef logic [PLANE_BITS-1:0] plane_en_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } fbx_mem_req_t;

  function automatic logic [CNT_W-1:0] count_planes(input plane_en_t en);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < PLANE_BITS; k++) begin
      if (en[k]) n = n + CNT_W'(1);
    end
    return n;
  endfunction

  // Mask of the plane whose ordinal among the enabled planes is "which".
  function automatic logic [PIX_W-1:0] mask_of_plane(input plane_en_t en,
                                                     input logic [CNT_W-1:0] which);
    logic [CNT_W-1:0] seen;
    logic [PIX_W-1:0] m;
    logic             found;
    seen  = '0;
    m     = '0;
    found = 1'b0;
    for (int k = 0; k < PLANE_BITS; k++) begin
      if (en[k] && !found) begin
        if (seen == which) begin
          m     = PIX_W'(1) << k;
          found = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COL_W-1:0] x,
                                                   input logic [ROW_W-1:0] y);
    return ADDR_W'(int'(y) * SCREEN_WIDTH + int'(x));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fbx_if.sv =====
// Channel interfaces of the framebuffer: command input, result output, plane register write.
// Depends on fbx_pkg for field widths.
`default_nettype none

interface fbx_in_if import fbx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  logic [PX_W-1:0] pos_x;
  logic [PY_W-1:0] pos_y;
  logic [RC_W-1:0] row_count;
  logic [7:0]      row_byte;

  modport source (output valid, mode, pos_x, pos_y, row_count, row_byte, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, row_count, row_byte, output ready);
endinterface

interface fbx_out_if import fbx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             collision;
  logic [PIX_W-1:0] pixel_value;
  logic             is_read;

  modport source (output valid, collision, pixel_value, is_read, input ready);
  modport sink   (input valid, collision, pixel_value, is_read, output ready);
endinterface

interface fbx_cfg_if import fbx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PLANE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fbx_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module fbx_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fbx_engine.sv =====
// Command sequencer: clear sweep, sprite draw read-modify-write, pixel read, result register.
// Depends on fbx_pkg and fbx_if; drives the pixel RAM through an fbx_mem_req_t.
`default_nettype none

module fbx_engine import fbx_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  fbx_in_if.sink             sprite_in,
  fbx_out_if.source          result_out,
  input  wire plane_en_t     plane_enable,
  output fbx_mem_req_t       mem_req,
  input  wire logic [PIX_W-1:0] mem_rdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_POST  = 3'd6;

  logic [2:0]         state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [PX_W-1:0]    origin_x;
  logic [PY_W-1:0]    origin_y;
  logic [RC_W-1:0]    rows_per_plane;
  logic [BYTES_W-1:0] bytes_taken;
  logic [RC_W-1:0]    row_idx;
  logic [CNT_W-1:0]   plane_ord;
  logic               hit_flag;
  logic [7:0]         byte_reg;
  logic [PIX_W-1:0]   mask_reg;
  logic [ROW_W-1:0]   y_row;
  logic [2:0]         pix_i;
  logic               last_byte;
  logic               rd_in_range;
  logic               s1_valid;
  logic [ADDR_W-1:0]  s1_addr;
  logic               res_collision;
  logic [PIX_W-1:0]   res_pixel;
  logic               res_is_read;

  logic               accept;
  logic [BYTES_W-1:0] total_now;
  logic [COL_W-1:0]   cur_x;
  logic               cur_en;
  logic [COL_W-1:0]   rd_x;
  logic [ROW_W-1:0]   rd_y;
  logic [ROW_W-1:0]   start_y;
  logic               out_free;

  assign sprite_in.ready = (state == ST_IDLE);
  assign accept          = sprite_in.valid && sprite_in.ready;
  assign out_free        = !result_out.valid || result_out.ready;

  assign total_now = BYTES_W'({3'b0, rows_per_plane} * {4'b0, count_planes(plane_enable)});
  assign cur_x     = {1'b0, origin_x} + COL_W'(pix_i);
  assign cur_en    = byte_reg[~pix_i] && (int'(cur_x) < SCREEN_WIDTH)
                     && (int'(y_row) < SCREEN_HEIGHT);
  assign rd_x      = {1'b0, sprite_in.pos_x};
  assign rd_y      = {1'b0, sprite_in.pos_y};
  assign start_y   = {1'b0, origin_y} + ROW_W'(row_idx);

  // Memory port selection: clear sweep owns the write port in ST_CLEAR, else the
  // modify stage writes back the pixel read in the previous cycle.
  always_comb begin
    mem_req = '0;
    if (state == ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_addr;
      mem_req.wdata = '0;
    end else if (s1_valid) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = s1_addr;
      mem_req.wdata = mem_rdata ^ mask_reg;
    end
    if (state == ST_DRAW) begin
      mem_req.re    = cur_en;
      mem_req.raddr = pixel_addr(cur_x, y_row);
    end else if (accept && sprite_in.mode == MODE_READ) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = pixel_addr(rd_x, rd_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      rows_per_plane <= '0;
      bytes_taken    <= '0;
      row_idx        <= '0;
      plane_ord      <= '0;
      hit_flag       <= 1'b0;
      s1_valid       <= 1'b0;
      origin_x       <= '0;
      origin_y       <= '0;
      result_out.valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      if (result_out.valid && result_out.ready) result_out.valid <= 1'b0;
      if (s1_valid && |(mem_rdata & mask_reg)) hit_flag <= 1'b1;

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            case (sprite_in.mode)
              MODE_CLEAR: begin
                state          <= ST_CLEAR;
                clr_addr       <= '0;
                rows_per_plane <= '0;
                bytes_taken    <= '0;
                hit_flag       <= 1'b0;
              end
              MODE_START: begin
                origin_x       <= sprite_in.pos_x;
                origin_y       <= sprite_in.pos_y;
                rows_per_plane <= sprite_in.row_count;
                bytes_taken    <= '0;
                row_idx        <= '0;
                plane_ord      <= '0;
                hit_flag       <= 1'b0;
                // Empty sprite finishes at once with no collision.
                if (sprite_in.row_count == '0 || count_planes(plane_enable) == '0) begin
                  res_collision <= 1'b0;
                  res_pixel     <= '0;
                  res_is_read   <= 1'b0;
                  state         <= ST_POST;
                end
              end
              MODE_ROW: begin
                // Drop a row byte that arrives with no draw active.
                if (bytes_taken < total_now) begin
                  mask_reg    <= mask_of_plane(plane_enable, plane_ord);
                  byte_reg    <= sprite_in.row_byte;
                  y_row       <= start_y;
                  pix_i       <= '0;
                  bytes_taken <= bytes_taken + BYTES_W'(1);
                  last_byte   <= (bytes_taken + BYTES_W'(1)) == total_now;
                  if (row_idx + RC_W'(1) == rows_per_plane) begin
                    row_idx   <= '0;
                    plane_ord <= plane_ord + CNT_W'(1);
                  end else begin
                    row_idx <= row_idx + RC_W'(1);
                  end
                  state <= ST_DRAW;
                end
              end
              MODE_READ: begin
                rd_in_range <= (int'(rd_x) < SCREEN_WIDTH) && (int'(rd_y) < SCREEN_HEIGHT);
                state       <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_DRAW: begin
          s1_valid <= cur_en;
          s1_addr  <= pixel_addr(cur_x, y_row);
          pix_i    <= pix_i + 3'd1;
          if (pix_i == 3'd7) state <= ST_WB;
        end
        ST_WB: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (last_byte) begin
            res_collision <= hit_flag;
            res_pixel     <= '0;
            res_is_read   <= 1'b0;
            state         <= ST_POST;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          res_collision <= 1'b0;
          res_pixel     <= rd_in_range ? mem_rdata : '0;
          res_is_read   <= 1'b1;
          state         <= ST_POST;
        end
        ST_POST: begin
          if (out_free) begin
            result_out.valid <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST && out_free) begin
      result_out.collision   <= res_collision;
      result_out.pixel_value <= res_pixel;
      result_out.is_read     <= res_is_read;
    end
  end

  a_wb_follows_draw: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($past(state) == ST_DRAW))
    else $error("write-back stage active outside a draw");

  a_no_wb_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s1_valid)
    else $error("draw write-back overlaps clear sweep");

  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    int'(bytes_taken) <= MAX_BYTES)
    else $error("byte count beyond largest sprite");

  a_post_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && out_free) |=> (result_out.valid && state == ST_IDLE))
    else $error("pending result not moved to output register");

endmodule

`default_nettype wire

// ===== hw/rtl/bitplane_sprite_xor_framebuffer_core.sv =====
// Top level of the bit-plane sprite XOR framebuffer: plane register, engine and pixel RAM.
// Depends on fbx_pkg, fbx_if, fbx_ram and fbx_engine.
`default_nettype none

// Usage
//   sprite_in carries one command per transaction: clear screen, start sprite,
//   sprite row byte or read pixel. result_out returns one transaction per finished
//   sprite (collision flag) and per pixel read (plane bits). cfg writes the 7-bit
//   plane enable register; it is always ready. The user is to write it only while idle;
//   the block itself does not enforce this.
// Sequence
//   Start: the next command can be taken in the cycle after acceptance; an empty
//   sprite goes straight to its post step. Row byte: read-modify-write of its eight
//   pixels over the single RAM read port, then write-back and flag settle, after
//   which the next command is taken; a last byte posts its result first. Read pixel:
//   RAM read, then the read and post steps. Clear: a sweep over all 8192 pixels.
// Reset
//   rst is synchronous. After it the same clearing pass over all 8192 pixels runs
//   with sprite_in.ready low; the plane register returns to plane 0 only.
// Stall
//   A result waiting in the output register does not block commands that give no
//   result; a command that gives one holds in its post step until the output
//   register frees.
module bitplane_sprite_xor_framebuffer_core import fbx_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  fbx_in_if.sink    sprite_in,
  fbx_out_if.source result_out,
  fbx_cfg_if.sink   cfg
);

  plane_en_t        plane_enable;
  fbx_mem_req_t     mem_req;
  logic [PIX_W-1:0] mem_rdata;

  // Take the plane register on every write; only bits 0..6 exist.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_enable <= plane_en_t'(1);
    end else if (cfg.valid && cfg.ready) begin
      plane_enable <= cfg.data;
    end
  end

  fbx_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .sprite_in    (sprite_in),
    .result_out   (result_out),
    .plane_enable (plane_enable),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  // One entry per pixel, eight bits each, of which bits 0..6 are plane bits.
  fbx_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PIX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== bench/fbx_draw_checker.sv =====
// Scoreboard for the bit-plane sprite framebuffer: shadow pixel store, draw state, result check.
// Depends on fbx_pkg and the channel interfaces of fbx_if; watches the channels only.
module fbx_draw_checker import fbx_pkg::*; (
  input  logic clk,
  input  logic rst,
  fbx_in_if    cmd,
  fbx_out_if   res,
  fbx_cfg_if   wr,
  output int   fail_count,
  output int   results_due
);

  typedef struct packed {
    logic             collision;
    logic [PIX_W-1:0] pixel_value;
    logic             is_read;
  } outcome_t;

  localparam int FIFO_DEPTH = 64;

  logic [PIX_W-1:0] shadow_fb [DEPTH];
  plane_en_t        planes_on;
  logic [PX_W-1:0]  org_x;
  logic [PY_W-1:0]  org_y;
  logic [RC_W-1:0]  sprite_rows;
  int               bytes_done;
  logic             hit;
  outcome_t         expect_fifo [FIFO_DEPTH];
  int               fifo_wr = 0;
  int               fifo_rd = 0;
  int               fails = 0;

  assign fail_count  = fails;
  assign results_due = fifo_wr - fifo_rd;

  task automatic wipe_screen();
    foreach (shadow_fb[a]) shadow_fb[a] = '0;
  endtask

  // Queue one expected result transaction.
  task automatic enqueue_outcome(input outcome_t o);
    if (fifo_wr - fifo_rd >= FIFO_DEPTH) begin
      $error("expected-result buffer overflow");
      fails++;
    end else begin
      expect_fifo[fifo_wr % FIFO_DEPTH] = o;
      fifo_wr++;
    end
  endtask

  // Plane bit for the n-th enabled plane, counted from bit 0 upward.
  function automatic logic [PIX_W-1:0] plane_bit(input int ordinal);
    int               seen;
    logic [PIX_W-1:0] m;
    seen = 0;
    m    = '0;
    for (int k = 0; k < PLANE_BITS; k++) begin
      if (planes_on[k]) begin
        if (seen == ordinal) m = PIX_W'(1) << k;
        seen++;
      end
    end
    return m;
  endfunction

  task automatic apply_command(input logic [1:0] op, input logic [PX_W-1:0] px,
                               input logic [PY_W-1:0] py, input logic [RC_W-1:0] rc,
                               input logic [7:0] rb);
    int               total;
    int               line;
    int               col;
    int               addr;
    logic [PIX_W-1:0] mask;
    outcome_t         o;
    o     = '{collision: 1'b0, pixel_value: '0, is_read: 1'b0};
    total = int'(sprite_rows) * $countones(planes_on);
    case (op)
      MODE_CLEAR: begin
        wipe_screen();
        sprite_rows = '0;
        bytes_done  = 0;
        hit         = 1'b0;
      end
      MODE_START: begin
        org_x       = px;
        org_y       = py;
        sprite_rows = rc;
        bytes_done  = 0;
        hit         = 1'b0;
        if (int'(rc) * $countones(planes_on) == 0) enqueue_outcome(o);
      end
      MODE_ROW: begin
        if (bytes_done < total) begin
          mask = plane_bit(bytes_done / int'(sprite_rows));
          line = int'(org_y) + bytes_done % int'(sprite_rows);
          for (int i = 0; i < 8; i++) begin
            col = int'(org_x) + i;
            // drop pixels that fall off the right or bottom edge
            if (rb[7-i] && col < SCREEN_WIDTH && line < SCREEN_HEIGHT) begin
              addr = line * SCREEN_WIDTH + col;
              if ((shadow_fb[addr] & mask) != '0) hit = 1'b1;
              shadow_fb[addr] = shadow_fb[addr] ^ mask;
            end
          end
          bytes_done++;
          if (bytes_done == total) begin
            o.collision = hit;
            enqueue_outcome(o);
          end
        end
      end
      MODE_READ: begin
        o.pixel_value = shadow_fb[int'(py) * SCREEN_WIDTH + int'(px)];
        o.is_read     = 1'b1;
        enqueue_outcome(o);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      wipe_screen();
      planes_on   = plane_en_t'(1);
      org_x       = '0;
      org_y       = '0;
      sprite_rows = '0;
      bytes_done  = 0;
      hit         = 1'b0;
      fifo_wr     = 0;
      fifo_rd     = 0;
    end else begin
      // A command taken at this edge still sees the plane register as it was.
      if (cmd.valid && cmd.ready)
        apply_command(cmd.mode, cmd.pos_x, cmd.pos_y, cmd.row_count, cmd.row_byte);
      if (wr.valid && wr.ready) planes_on = wr.data;
      if (res.valid && res.ready) begin
        if (fifo_wr == fifo_rd) begin
          $error("unexpected result: collision %0d pixel_value %0h is_read %0d",
                 res.collision, res.pixel_value, res.is_read);
          fails++;
        end else begin
          want = expect_fifo[fifo_rd % FIFO_DEPTH];
          fifo_rd++;
          if (res.collision !== want.collision) begin
            $error("collision: expected %0d, got %0d", want.collision, res.collision);
            fails++;
          end
          if (res.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0h, got %0h", want.pixel_value, res.pixel_value);
            fails++;
          end
          if (res.is_read !== want.is_read) begin
            $error("is_read: expected %0d, got %0d", want.is_read, res.is_read);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the framebuffer bench: clock, reset, command and plane-register stimulus, verdict.
// Depends on fbx_pkg, fbx_if, the core and fbx_draw_checker, which does all prediction.
module tb;
  import fbx_pkg::*;

  logic      clk;
  logic      rst;
  int        fail_count;
  int        results_due;
  int        items_sent = 0;
  int        clears_left = 3;
  bit        tx_quiet = 1'b0;
  bit        rx_quiet = 1'b0;
  int        rx_hold_cycles = 0;
  plane_en_t planes_now = plane_en_t'(1);

  // Plane settings per random phase; entry 5 is redrawn at random.
  plane_en_t plane_plan [8] = '{7'h01, 7'h7F, 7'h00, 7'h40, 7'h55, 7'h2A, 7'h03, 7'h7F};
  int        phase_quota [8] = '{140, 160, 40, 120, 130, 130, 120, 140};

  fbx_in_if  in_ch ();
  fbx_out_if res_ch ();
  fbx_cfg_if cfg_ch ();

  bitplane_sprite_xor_framebuffer_core uut (
    .clk        (clk),
    .rst        (rst),
    .sprite_in  (in_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  fbx_draw_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (in_ch),
    .res         (res_ch),
    .wr          (cfg_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: draw a stall per transaction, and serve one long hold-off on request
  // so that the output register backs up into the command channel.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      // hold ready until a result transaction goes through
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Offer one command and hold it until the transaction completes. Keep valid high
  // straight into the next command when no gap is drawn, so valid never toggles
  // twice in one step.
  task automatic issue(input logic [1:0] op, input logic [PX_W-1:0] px,
                       input logic [PY_W-1:0] py, input logic [RC_W-1:0] rc,
                       input logic [7:0] rb, input bit counted);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= op;
    in_ch.pos_x     <= px;
    in_ch.pos_y     <= py;
    in_ch.row_count <= rc;
    in_ch.row_byte  <= rb;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) items_sent++;
  endtask

  // Flush the block: a pixel read comes back only after every earlier command is done,
  // so once nothing is owed the core is idle and the plane register may change.
  task automatic settle();
    issue(MODE_READ, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom), 1'b0);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_planes(input plane_en_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    planes_now = v;
  endtask

  // Read a pixel in the sprite box or the row just below it, so reads see drawn data.
  task automatic read_near(input logic [PX_W-1:0] x, input logic [PY_W-1:0] y,
                           input logic [RC_W-1:0] rows);
    issue(MODE_READ, PX_W'(int'(x) + $urandom_range(0, 7)),
          PY_W'(int'(y) + $urandom_range(0, int'(rows))), RC_W'($urandom), 8'($urandom), 1'b1);
  endtask

  // One sprite: start, then the row bytes for every enabled plane. About one in ten
  // is cut short or runs past its end; extra bytes land on no draw and are ignored.
  task automatic random_sprite();
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
    logic [RC_W-1:0] rows;
    int              total;
    int              nbytes;
    x      = ($urandom_range(0, 3) == 0) ? PX_W'($urandom_range(120, 127)) : PX_W'($urandom);
    y      = ($urandom_range(0, 3) == 0) ? PY_W'($urandom_range(56, 63)) : PY_W'($urandom);
    rows   = ($urandom_range(0, 9) == 0) ? RC_W'($urandom_range(4, 15))
                                         : RC_W'($urandom_range(1, 3));
    total  = int'(rows) * $countones(planes_now);
    nbytes = total;
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, total + 2);
    issue(MODE_START, x, y, rows, 8'($urandom), 1'b1);
    for (int n = 0; n < nbytes; n++) begin
      if ($urandom_range(0, 7) == 0) read_near(x, y, rows);
      issue(MODE_ROW, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom),
            n < total);
    end
    repeat ($urandom_range(1, 2)) read_near(x, y, rows);
  endtask

  initial begin
    int goal;
    int pick;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_CLEAR;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.row_count <= '0;
    in_ch.row_byte  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first command waits out the clearing sweep after reset.
    issue(MODE_READ, 7'd0, 6'd0, 4'd0, 8'h00, 1'b1);
    // Sprite hanging off the bottom-right corner: its right half clips away.
    issue(MODE_START, 7'd124, 6'd62, 4'd2, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hFF, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h81, 1'b1);
    // Same spot again: every drawn pixel was already set, so collision.
    issue(MODE_START, 7'd124, 6'd62, 4'd1, 8'hFF, 1'b1);
    issue(MODE_ROW, 7'd127, 6'd63, 4'd15, 8'hFF, 1'b1);
    issue(MODE_READ, 7'd127, 6'd63, 4'd15, 8'hFF, 1'b1);
    // Zero rows finish at once; a byte after that finds no draw.
    issue(MODE_START, 7'd3, 6'd3, 4'd0, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h5A, 1'b0);
    // Restart mid-draw: the first sprite is dropped without a result.
    issue(MODE_START, 7'd5, 6'd5, 4'd2, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h3C, 1'b1);
    issue(MODE_START, 7'd0, 6'd0, 4'd1, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h80, 1'b1);
    // Clear in the middle of a draw ends it; the next byte is ignored.
    issue(MODE_START, 7'd0, 6'd0, 4'd15, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hFF, 1'b1);
    issue(MODE_CLEAR, 7'd127, 6'd63, 4'd15, 8'hFF, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hFF, 1'b0);
    issue(MODE_READ, 7'd124, 6'd62, 4'd0, 8'h00, 1'b1);
    // No plane enabled: a nonzero row count still gives an empty sprite.
    settle();
    write_planes(7'h00);
    issue(MODE_START, 7'd64, 6'd32, 4'd5, 8'h00, 1'b1);
    // Two planes, taken lowest bit first.
    settle();
    write_planes(7'h41);
    issue(MODE_START, 7'd120, 6'd60, 4'd1, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hFF, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hF0, 1'b1);
    issue(MODE_READ, 7'd123, 6'd60, 4'd0, 8'h00, 1'b1);
    // Shrink the plane set while a draw waits for bytes: the draw follows the new total.
    issue(MODE_START, 7'd30, 6'd20, 4'd2, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h00, 1'b1);
    settle();
    write_planes(7'h01);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h18, 1'b1);
    // Drop the total below the bytes already taken: the draw ends with no result.
    settle();
    write_planes(7'h41);
    issue(MODE_START, 7'd40, 6'd40, 4'd1, 8'h00, 1'b1);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'hAA, 1'b1);
    settle();
    write_planes(7'h00);
    issue(MODE_ROW, 7'd0, 6'd0, 4'd0, 8'h55, 1'b0);

    // Random phases, one plane setting each, written only with the core drained.
    plane_plan[5] = plane_en_t'($urandom);
    goal = items_sent;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_planes(plane_plan[ph]);
      tx_quiet = (ph % 3 == 1);
      rx_quiet = (ph % 4 == 2);
      // One long result hold-off while commands keep flowing back to back.
      if (ph == 1) rx_hold_cycles = 400;
      goal += phase_quota[ph];
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          random_sprite();
        end else if (pick < 80) begin
          issue(MODE_READ, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom),
                1'b1);
        end else if (pick < 86) begin
          // stray byte: usually hits no draw, sometimes extends a dropped one
          issue(MODE_ROW, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom),
                1'b0);
        end else if (pick < 92) begin
          issue(MODE_START, PX_W'($urandom), PY_W'($urandom), 4'd0, 8'($urandom), 1'b1);
        end else if (pick < 98 || clears_left == 0) begin
          // start left without its bytes; the next start abandons it
          issue(MODE_START, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom),
                1'b1);
        end else begin
          clears_left--;
          issue(MODE_CLEAR, PX_W'($urandom), PY_W'($urandom), RC_W'($urandom), 8'($urandom),
                1'b1);
        end
      end
    end

    // Drain, give the core time to post anything stray, then judge.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fbx_pkg.sv
hw/rtl/fbx_if.sv
hw/rtl/fbx_ram.sv
hw/rtl/fbx_engine.sv
hw/rtl/bitplane_sprite_xor_framebuffer_core.sv
bench/fbx_draw_checker.sv
bench/tb.sv
